// File: rtl/split_cache_lru_controller_assert.svh
// Assertion macros used by the checker file of the split cache controller.
// Expects clk and arst_n in scope where the macros are used.
`ifndef SPLIT_CACHE_LRU_CONTROLLER_ASSERT_SVH
`define SPLIT_CACHE_LRU_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define SCL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/scl_pkg.sv
// Shared types and constants of the split cache LRU controller.
// No dependencies.
`default_nettype none
package scl_pkg;
	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic update;
	} cmd_t;

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_FETCH = 2'd2;

	localparam logic [1:0] CFG_CACHE = 2'd0;
	localparam logic [1:0] CFG_BLOCK = 2'd1;
	localparam logic [1:0] CFG_WAYS  = 2'd2;

	localparam logic [3:0] CACHE_MIN = 4'd10;
	localparam logic [3:0] CACHE_MAX = 4'd14;
	localparam logic [2:0] BLOCK_MIN = 3'd4;
	localparam logic [2:0] BLOCK_MAX = 3'd6;

	localparam int AGE_W = 3;
	localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;
	localparam int CNT_W = 32;
	localparam int OUT_W = 104;
endpackage
`default_nettype wire

// File: rtl/scl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module scl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// File: rtl/scl_ctrl.sv
// Controller of the split cache: clearing sweep, lookup sequencing, result slot.
// Depends on scl_pkg.
`default_nettype none
module scl_ctrl #(
	parameter int RAM_AW = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      scl_pkg::cmd_t     cmd,
	output      logic [RAM_AW-1:0] clr_addr
);
	scl_pkg::state_t   state_q, state_d;
	logic [RAM_AW-1:0] clr_q;
	logic              ovalid_q;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			scl_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (&clr_q) begin
					state_d = scl_pkg::ST_IDLE;
				end
			end
			scl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = scl_pkg::ST_LOOK;
				end
			end
			scl_pkg::ST_LOOK: begin
				if (!ovalid_q || out_ready) begin
					cmd.update = 1'b1;
					state_d    = scl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = scl_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= scl_pkg::ST_CLEAR;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.update) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign out_valid = ovalid_q;
	assign clr_addr  = clr_q;
endmodule
`default_nettype wire

// File: rtl/scl_dp.sv
// Datapath of the split cache: geometry registers, tag/state RAM, hit and
// victim selection, LRU aging, miss and write-back counters, result register.
// Depends on scl_pkg and scl_ram.
`default_nettype none
module scl_dp #(
	parameter int MAX_LINES  = 1024,
	parameter int MAX_WAYS   = 8,
	parameter int ADDR_WIDTH = 32
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     cfg_we,
	input  wire logic [1:0]                               cfg_index,
	input  wire logic [3:0]                               cfg_data,
	input  wire logic [1:0]                               in_req,
	input  wire logic [31:0]                              in_addr,
	input  wire scl_pkg::cmd_t                            cmd,
	input  wire logic [$clog2(MAX_LINES/MAX_WAYS):0]      clr_addr,
	output      logic [scl_pkg::OUT_W-1:0]                out_data
);
	localparam int LL     = $clog2(MAX_LINES);
	localparam int LW     = $clog2(MAX_WAYS);
	localparam int BW     = (LW > 0) ? LW : 1;
	localparam int ROWS   = MAX_LINES / MAX_WAYS;
	localparam int RW     = $clog2(ROWS);
	localparam int TW     = ADDR_WIDTH - 7;
	localparam int EW     = TW + 2 + scl_pkg::AGE_W;
	localparam int ROW_W  = MAX_WAYS * EW;
	localparam int AW     = ADDR_WIDTH;
	localparam int CW     = scl_pkg::CNT_W;

	logic [3:0] csz_q;
	logic [2:0] bsz_q;
	logic [1:0] wlg_q;

	logic [1:0]    req_q;
	logic [AW-1:0] addr_q;

	logic [3:0]    sets_log2;
	logic [3:0]    tag_sh;
	logic [2:0]    ewl;
	logic [4:0]    nways;

	logic [LL-1:0] line_in, line_st;
	logic [RW:0]   raddr, waddr;
	logic [ROW_W-1:0] rdata, wdata;
	logic          we;

	logic [CW-1:0] dmiss_q, imiss_q, wbcnt_q;
	logic [CW-1:0] dmiss_d, imiss_d, wbcnt_d;
	logic [scl_pkg::OUT_W-1:0] out_q;

	logic [BW-1:0]    base_bk;
	logic [BW-1:0]    bk     [MAX_WAYS];
	logic             act    [MAX_WAYS];
	logic             val    [MAX_WAYS];
	logic             dty    [MAX_WAYS];
	logic [2:0]       age    [MAX_WAYS];
	logic [TW-1:0]    tg     [MAX_WAYS];
	logic [EW-1:0]    ent;
	logic [TW-1:0]    tag_new;
	logic             hit, found, evict;
	logic [BW-1:0]    sel;
	logic [2:0]       best;
	logic [3:0]       old_age;
	logic [ROW_W-1:0] nrow;
	logic             is_data, is_inst, is_wr;

	function automatic logic [LL-1:0] line_of(input logic [AW-1:0] a, input logic [2:0] b,
			input logic [3:0] sl, input logic [2:0] e);
		logic [AW-1:0] s;
		s = (a >> b) & ~({AW{1'b1}} << sl);
		return LL'(s << e);
	endfunction

	always_comb begin
		sets_log2 = csz_q - 4'(bsz_q) - 4'(wlg_q);
		tag_sh    = csz_q - 4'(wlg_q);
		ewl       = (3'(wlg_q) > 3'(LW)) ? 3'(LW) : 3'(wlg_q);
		nways     = 5'd1 << ewl;
		line_in   = line_of(AW'(in_addr), bsz_q, sets_log2, ewl);
		line_st   = line_of(addr_q, bsz_q, sets_log2, ewl);
		raddr     = {in_req == scl_pkg::REQ_FETCH, RW'(line_in >> LW)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csz_q <= scl_pkg::CACHE_MIN;
			bsz_q <= scl_pkg::BLOCK_MIN;
			wlg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scl_pkg::CFG_CACHE: begin
					csz_q <= (cfg_data < scl_pkg::CACHE_MIN) ? scl_pkg::CACHE_MIN :
						((cfg_data > scl_pkg::CACHE_MAX) ? scl_pkg::CACHE_MAX : cfg_data);
				end
				scl_pkg::CFG_BLOCK: begin
					bsz_q <= (cfg_data[2:0] < scl_pkg::BLOCK_MIN) ? scl_pkg::BLOCK_MIN :
						((cfg_data[2:0] > scl_pkg::BLOCK_MAX) ? scl_pkg::BLOCK_MAX :
						cfg_data[2:0]);
				end
				scl_pkg::CFG_WAYS: begin
					wlg_q <= cfg_data[1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= in_req;
			addr_q <= AW'(in_addr);
		end
	end

	always_comb begin
		is_data = (req_q == scl_pkg::REQ_READ) || (req_q == scl_pkg::REQ_WRITE);
		is_inst = (req_q == scl_pkg::REQ_FETCH);
		is_wr   = (req_q == scl_pkg::REQ_WRITE);
		tag_new = TW'(addr_q >> tag_sh);
		base_bk = BW'(line_st) & BW'(MAX_WAYS - 1);
		for (int i = 0; i < MAX_WAYS; i++) begin
			bk[i]  = base_bk | BW'(i);
			ent    = rdata[bk[i]*EW +: EW];
			act[i] = 5'(i) < nways;
			age[i] = ent[2:0];
			dty[i] = ent[3];
			val[i] = ent[4];
			tg[i]  = ent[EW-1:5];
		end
		hit   = 1'b0;
		found = 1'b0;
		sel   = '0;
		best  = '0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (!hit && act[i] && val[i] && tg[i] == tag_new) begin
				hit = 1'b1;
				sel = BW'(i);
			end
		end
		if (!hit) begin
			for (int i = 0; i < MAX_WAYS; i++) begin
				if (!found && act[i] && !val[i]) begin
					found = 1'b1;
					sel   = BW'(i);
				end
			end
			if (!found) begin
				for (int i = 0; i < MAX_WAYS; i++) begin
					if (act[i] && (i == 0 || age[i] > best)) begin
						best = age[i];
						sel  = BW'(i);
					end
				end
			end
		end
		old_age = val[sel] ? {1'b0, age[sel]} : 4'd8;
		evict   = is_data && !hit && val[sel] && dty[sel];
		nrow    = rdata;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (act[i]) begin
				if (BW'(i) == sel) begin
					nrow[bk[i]*EW +: EW] = {hit ? tg[i] : tag_new, 1'b1,
						is_data && (is_wr || (hit && dty[i])), 3'd0};
				end else if (val[i] && {1'b0, age[i]} < old_age &&
						age[i] < scl_pkg::AGE_MAX) begin
					nrow[bk[i]*EW +: EW] = {tg[i], val[i], dty[i], age[i] + 3'd1};
				end
			end
		end
	end

	always_comb begin
		dmiss_d = dmiss_q;
		imiss_d = imiss_q;
		wbcnt_d = wbcnt_q;
		if (is_data && !hit && !(&dmiss_q)) begin
			dmiss_d = dmiss_q + 1'b1;
		end
		if (is_inst && !hit && !(&imiss_q)) begin
			imiss_d = imiss_q + 1'b1;
		end
		if (evict && !(&wbcnt_q)) begin
			wbcnt_d = wbcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmiss_q <= '0;
			imiss_q <= '0;
			wbcnt_q <= '0;
		end else if (cmd.update) begin
			dmiss_q <= dmiss_d;
			imiss_q <= imiss_d;
			wbcnt_q <= wbcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (is_data || is_inst) begin
				out_q <= {3'b000, wbcnt_d, imiss_d, dmiss_d, 3'(sel), evict, hit};
			end else begin
				out_q <= {3'b000, wbcnt_q, imiss_q, dmiss_q, 3'd0, 1'b0, 1'b0};
			end
		end
	end

	assign we    = cmd.clear || (cmd.update && (is_data || is_inst));
	assign waddr = cmd.clear ? clr_addr : {is_inst, RW'(line_st >> LW)};
	assign wdata = cmd.clear ? '0 : nrow;
	assign out_data = out_q;

	scl_ram #(
		.WIDTH(ROW_W),
		.DEPTH(2 * ROWS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.load),
		.raddr(raddr),
		.rdata(rdata)
	);
endmodule
`default_nettype wire

// File: rtl/split_cache_lru_controller.sv
// Top level of the split instruction/data cache tag and LRU controller.
// Depends on scl_pkg, scl_ctrl, scl_dp (and scl_ram below it).
//
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tuser req_type, tdata address
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata result and counters
// cfg       in         cfg_we                       cfg_index, cfg_data
//
// Each request is handled as a tag/state RAM read, then a row write-back.
// The read of the row RAM is registered and returns all ways of a set in one
// word; a new request is taken only after the write-back of the last one.
// After reset a clearing sweep zeroes all 2*MAX_LINES/MAX_WAYS rows (256 by
// default) of both caches; s_axis_tready stays low during it.
// A waiting result holds the lookup, and no new request is taken meanwhile.
`default_nettype none
module split_cache_lru_controller #(
	parameter int MAX_LINES  = 1024,
	parameter int MAX_WAYS   = 8,
	parameter int ADDR_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [3:0]                    cfg_data,
	input  wire logic                          s_axis_tvalid,
	output      logic                          s_axis_tready,
	input  wire logic [31:0]                   s_axis_tdata,  // address
	input  wire logic [1:0]                    s_axis_tuser,  // req_type
	output      logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// hit, wrote_back, way_used[2:0], data_misses[31:0], inst_misses[31:0],
	// memory_writes[31:0], zero pad
	output      logic [scl_pkg::OUT_W-1:0]     m_axis_tdata
);
	localparam int RAM_AW = $clog2(MAX_LINES / MAX_WAYS) + 1;

	scl_pkg::cmd_t     cmd;
	logic [RAM_AW-1:0] clr_addr;

	scl_ctrl #(
		.RAM_AW(RAM_AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.cmd      (cmd),
		.clr_addr (clr_addr)
	);

	scl_dp #(
		.MAX_LINES (MAX_LINES),
		.MAX_WAYS  (MAX_WAYS),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_req   (s_axis_tuser),
		.in_addr  (s_axis_tdata),
		.cmd      (cmd),
		.clr_addr (clr_addr),
		.out_data (m_axis_tdata)
	);
endmodule
`default_nettype wire

// File: rtl/scl_checker.sv
// Port-level checker for the split cache controller, bound to the top level.
// Depends on scl_pkg and split_cache_lru_controller_assert.svh.
`default_nettype none
`include "split_cache_lru_controller_assert.svh"
module scl_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_axis_tvalid,
	input wire logic                      s_axis_tready,
	input wire logic [1:0]                s_axis_tuser,
	input wire logic                      m_axis_tvalid,
	input wire logic                      m_axis_tready,
	input wire logic [scl_pkg::OUT_W-1:0] m_axis_tdata
);
	logic s_acc;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	`SCL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")
	`SCL_ASSERT_NEXT(a_two_cycles, s_acc, !s_axis_tready, "request taken on consecutive cycles")
	`SCL_ASSERT_NOW(a_hit_no_wb, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[1], "write-back reported on a hit")
	`SCL_ASSERT_NOW(a_rise_src, $rose(m_axis_tvalid), $past(s_acc, 2), "result beat without a request")
	`SCL_ASSERT_NOW(a_inst_no_wb, $rose(m_axis_tvalid) && $past(s_axis_tuser, 2) == scl_pkg::REQ_FETCH, !m_axis_tdata[1], "write-back on a fetch")
endmodule

bind split_cache_lru_controller scl_checker u_scl_checker (.*);
`default_nettype wire
